[rtl/cts_pkg.sv]
package cts_pkg;

    localparam int MAX_TASKS    = 32;
    localparam int TIME_BITS    = 10;
    localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W        = $clog2(MAX_TASKS + 1);
    localparam int TASK_INDEX_W = 6;
    localparam int POLICY_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 10;

    localparam logic [TIME_BITS-1:0] TIME_LIMIT_RESET = TIME_BITS'(1000);

    localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SJF  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_RR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 2'd1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [TIME_BITS-1:0] arrival_time;
        logic [TIME_BITS-1:0] service_time;
    } cts_in_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]    tick_time;
        logic                    cpu_busy;
        logic [TASK_INDEX_W-1:0] task_index;
        logic [TIME_BITS-1:0]    remaining_before;
        logic                    task_finished;
        logic [TIME_BITS:0]      finish_time;
        logic [TIME_BITS:0]      turnaround;
        logic [TIME_BITS-1:0]    waited;
        logic                    all_done;
        logic                    limit_hit;
        logic                    table_full;
    } cts_out_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] service;
        logic [TIME_BITS-1:0] remaining;
        logic [TIME_BITS-1:0] wait_cnt;
    } cts_entry_t;

    typedef struct packed {
        logic             we_arrival;
        logic             we_service;
        logic             we_remaining;
        logic             we_wait;
        logic [IDX_W-1:0] addr;
        cts_entry_t       data;
    } cts_tbl_ctl_t;

endpackage

[rtl/cts_table.sv]
module cts_table (
    input  logic                 clk,
    input  cts_pkg::cts_tbl_ctl_t ctl,
    output cts_pkg::cts_entry_t  rd
);
    import cts_pkg::*;

    logic [TIME_BITS-1:0] arrival_mem   [MAX_TASKS];
    logic [TIME_BITS-1:0] service_mem   [MAX_TASKS];
    logic [TIME_BITS-1:0] remaining_mem [MAX_TASKS];
    logic [TIME_BITS-1:0] wait_mem      [MAX_TASKS];

    always_ff @(posedge clk)
    begin
        if (ctl.we_arrival)
        begin
            arrival_mem[ctl.addr] <= ctl.data.arrival;
        end
        if (ctl.we_service)
        begin
            service_mem[ctl.addr] <= ctl.data.service;
        end
        if (ctl.we_remaining)
        begin
            remaining_mem[ctl.addr] <= ctl.data.remaining;
        end
        if (ctl.we_wait)
        begin
            wait_mem[ctl.addr] <= ctl.data.wait_cnt;
        end
    end

    always_comb
    begin
        rd.arrival   = arrival_mem[ctl.addr];
        rd.service   = service_mem[ctl.addr];
        rd.remaining = remaining_mem[ctl.addr];
        rd.wait_cnt  = wait_mem[ctl.addr];
    end

endmodule

[rtl/cts_seq.sv]
module cts_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cts_pkg::cts_in_t              in_data,
    input  logic [cts_pkg::POLICY_W-1:0]  policy,
    input  logic [cts_pkg::TIME_BITS-1:0] time_limit,
    output logic                          res_valid,
    input  logic                          res_take,
    output cts_pkg::cts_out_t             res_data,
    output cts_pkg::cts_tbl_ctl_t         tbl_ctl,
    input  cts_pkg::cts_entry_t           tbl_rd
);
    import cts_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_RESOLVE = 3'd2;
    localparam logic [2:0] S_APPLY   = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     fin_cnt_reg, fin_cnt_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [IDX_W-1:0]     rot_reg, rot_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [TIME_BITS-1:0] best_rem_reg, best_rem_next;
    logic                 best_inc_reg, best_inc_next;
    logic                 alt_found_reg, alt_found_next;
    logic [IDX_W-1:0]     alt_reg, alt_next;
    logic                 alt_inc_reg, alt_inc_next;
    logic                 seen_reg, seen_next;
    logic                 run_inc_reg, run_inc_next;
    cts_out_t             res_reg, res_next;

    logic                 rdy;
    logic                 can_inc;
    logic                 last_entry;
    logic                 run_found;
    logic [IDX_W-1:0]     run_idx;
    logic                 run_inc;
    logic [TIME_BITS-1:0] new_rem;
    logic [TIME_BITS-1:0] wait_fix;
    logic [TIME_BITS-1:0] load_svc;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        res_data          = res_reg;
        res_data.all_done = (fin_cnt_reg == count_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        fin_cnt_next   = fin_cnt_reg;
        time_next      = time_reg;
        rot_next       = rot_reg;
        addr_next      = addr_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_rem_next  = best_rem_reg;
        best_inc_next  = best_inc_reg;
        alt_found_next = alt_found_reg;
        alt_next       = alt_reg;
        alt_inc_next   = alt_inc_reg;
        seen_next      = seen_reg;
        run_inc_next   = run_inc_reg;
        res_next       = res_reg;

        tbl_ctl      = '0;
        tbl_ctl.addr = (state_reg == S_IDLE) ? count_reg[IDX_W-1:0] : addr_reg;

        // One comparator pair serves the whole scan, one entry per cycle.
        rdy        = (tbl_rd.arrival <= time_reg) && (tbl_rd.remaining != '0);
        can_inc    = rdy && (tbl_rd.wait_cnt != '1);
        last_entry = (CNT_W'(addr_reg) == (count_reg - CNT_W'(1)));

        run_found = 1'b0;
        run_idx   = best_reg;
        run_inc   = best_inc_reg;
        if (found_reg)
        begin
            run_found = 1'b1;
        end
        else if ((policy == POL_RR) && alt_found_reg)
        begin
            run_found = 1'b1;
            run_idx   = alt_reg;
            run_inc   = alt_inc_reg;
        end

        new_rem  = tbl_rd.remaining - TIME_BITS'(1);
        wait_fix = tbl_rd.wait_cnt - TIME_BITS'(run_inc_reg);
        load_svc = (in_data.service_time == '0) ? TIME_BITS'(1) : in_data.service_time;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next           = '0;
                    res_next.tick_time = time_reg;
                    state_next         = S_DONE;
                    if (in_data.mode == MODE_LOAD)
                    begin
                        if (count_reg == CNT_W'(MAX_TASKS))
                        begin
                            res_next.table_full = 1'b1;
                        end
                        else
                        begin
                            tbl_ctl.we_arrival     = 1'b1;
                            tbl_ctl.we_service     = 1'b1;
                            tbl_ctl.we_remaining   = 1'b1;
                            tbl_ctl.we_wait        = 1'b1;
                            tbl_ctl.data.arrival   = in_data.arrival_time;
                            tbl_ctl.data.service   = load_svc;
                            tbl_ctl.data.remaining = load_svc;
                            tbl_ctl.data.wait_cnt  = '0;
                            res_next.task_index    = TASK_INDEX_W'(count_reg[IDX_W-1:0]);
                            count_next             = count_reg + CNT_W'(1);
                        end
                    end
                    else if (time_reg >= time_limit)
                    begin
                        res_next.limit_hit = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        time_next = time_reg + TIME_BITS'(1);
                    end
                    else
                    begin
                        addr_next      = '0;
                        found_next     = 1'b0;
                        alt_found_next = 1'b0;
                        seen_next      = 1'b0;
                        state_next     = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Every ready task whose wait count is not saturated is charged a wait
                // unit here; the one that ends up running gets its unit taken back in the apply step.
                if (can_inc)
                begin
                    tbl_ctl.we_wait       = 1'b1;
                    tbl_ctl.data.wait_cnt = tbl_rd.wait_cnt + TIME_BITS'(1);
                end
                case (policy)
                    POL_SJF:
                    begin
                        if (rdy && (!found_reg || (tbl_rd.remaining < best_rem_reg)))
                        begin
                            found_next    = 1'b1;
                            best_next     = addr_reg;
                            best_rem_next = tbl_rd.remaining;
                            best_inc_next = can_inc;
                        end
                    end
                    POL_RR:
                    begin
                        // First ready task at or after the rotation point, with the
                        // first ready task overall as the wrap-around fallback.
                        if (rdy && !found_reg && (addr_reg >= rot_reg))
                        begin
                            found_next    = 1'b1;
                            best_next     = addr_reg;
                            best_inc_next = can_inc;
                        end
                        if (rdy && !alt_found_reg)
                        begin
                            alt_found_next = 1'b1;
                            alt_next       = addr_reg;
                            alt_inc_next   = can_inc;
                        end
                    end
                    default:
                    begin
                        // The oldest unfinished task runs only once it has arrived.
                        if ((tbl_rd.remaining != '0) && !seen_reg)
                        begin
                            seen_next = 1'b1;
                            if (rdy)
                            begin
                                found_next    = 1'b1;
                                best_next     = addr_reg;
                                best_inc_next = can_inc;
                            end
                        end
                    end
                endcase
                if (last_entry)
                begin
                    state_next = S_RESOLVE;
                end
                else
                begin
                    addr_next = addr_reg + IDX_W'(1);
                end
            end

            S_RESOLVE:
            begin
                if (run_found)
                begin
                    addr_next    = run_idx;
                    run_inc_next = run_inc;
                    if (policy == POL_RR)
                    begin
                        rot_next = (CNT_W'(run_idx) == (count_reg - CNT_W'(1))) ?
                                   '0 : run_idx + IDX_W'(1);
                    end
                    state_next = S_APPLY;
                end
                else
                begin
                    time_next  = time_reg + TIME_BITS'(1);
                    state_next = S_DONE;
                end
            end

            S_APPLY:
            begin
                tbl_ctl.we_remaining      = 1'b1;
                tbl_ctl.we_wait           = 1'b1;
                tbl_ctl.data.remaining    = new_rem;
                tbl_ctl.data.wait_cnt     = wait_fix;
                res_next.cpu_busy         = 1'b1;
                res_next.task_index       = TASK_INDEX_W'(addr_reg);
                res_next.remaining_before = tbl_rd.remaining;
                if (new_rem == '0)
                begin
                    res_next.task_finished = 1'b1;
                    res_next.finish_time   = {1'b0, time_reg} + (TIME_BITS + 1)'(1);
                    res_next.turnaround    = {1'b0, wait_fix} + {1'b0, tbl_rd.service};
                    res_next.waited        = wait_fix;
                    fin_cnt_next           = fin_cnt_reg + CNT_W'(1);
                end
                time_next  = time_reg + TIME_BITS'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fin_cnt_reg   <= '0;
            time_reg      <= '0;
            rot_reg       <= '0;
            found_reg     <= 1'b0;
            alt_found_reg <= 1'b0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fin_cnt_reg   <= fin_cnt_next;
            time_reg      <= time_next;
            rot_reg       <= rot_next;
            found_reg     <= found_next;
            alt_found_reg <= alt_found_next;
            seen_reg      <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        best_reg     <= best_next;
        best_rem_reg <= best_rem_next;
        best_inc_reg <= best_inc_next;
        alt_reg      <= alt_next;
        alt_inc_reg  <= alt_inc_next;
        run_inc_reg  <= run_inc_next;
        res_reg      <= res_next;
    end

endmodule

[rtl/cpu_task_scheduler_top.sv]
// Single-CPU task scheduler. A load item stores one task in the table and a tick item
// runs one time unit under the fifo, preemptive shortest-job-first or round-robin
// policy; every item returns exactly one result item. The block works on one item at a
// time. A load, a refused tick or a tick with an empty table is handled in the idle
// state and goes straight to the result; a tick with loaded tasks scans the task table
// through its single read/write port, one entry per cycle, followed by a resolve step,
// an update step at the chosen task when one is ready, and the result step.
// The result sits in an output register, so the next item is taken while it waits.
// Configuration writes are always accepted and belong in idle periods.
module cpu_task_scheduler_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cts_pkg::cts_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cts_pkg::cts_out_t              out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cts_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cts_pkg::*;

    logic [POLICY_W-1:0]  policy_reg;
    logic [TIME_BITS-1:0] time_limit_reg;
    logic                 out_valid_reg;
    cts_out_t             out_data_reg;

    logic                 res_valid;
    logic                 res_take;
    cts_out_t             res_data;
    cts_tbl_ctl_t         tbl_ctl;
    cts_entry_t           tbl_rd;

    assign cfg_ready = 1'b1;
    assign res_take  = res_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cts_table u_table (
        .clk (clk),
        .ctl (tbl_ctl),
        .rd  (tbl_rd)
    );

    cts_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .policy     (policy_reg),
        .time_limit (time_limit_reg),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res_data   (res_data),
        .tbl_ctl    (tbl_ctl),
        .tbl_rd     (tbl_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg     <= POL_FIFO;
            time_limit_reg <= TIME_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_POLICY:     policy_reg     <= cfg_data[POLICY_W-1:0];
                    REG_TIME_LIMIT: time_limit_reg <= cfg_data[TIME_BITS-1:0];
                    default:        ;
                endcase
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res_data;
        end
    end

endmodule
